// ===== src/sfs_pkg.sv =====
// Shared types, constants and functions of the SimHash fingerprint stream core.
package sfs_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned KEY_W      = 31;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned SIZE_W     = 8;
  localparam int unsigned PRINT_W    = 32;
  localparam int unsigned DIST_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [HASH_W-1:0] HASH_MULT = 32'd131;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TOKEN_MODE      = 2'd0;
  localparam cfg_idx_t CFG_TOKEN_SIZE      = 2'd1;
  localparam cfg_idx_t CFG_REFERENCE_PRINT = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] weight;
  } close_evt_t;

  typedef struct packed {
    logic [PRINT_W-1:0] fingerprint;
    logic [DIST_W-1:0]  distance;
  } result_t;

  function automatic logic [DIST_W-1:0] popcount32(input logic [PRINT_W-1:0] v);
    logic [PRINT_W-1:0] s;
    s = (v & 32'h5555_5555) + ((v >> 1) & 32'h5555_5555);
    s = (s & 32'h3333_3333) + ((s >> 2) & 32'h3333_3333);
    s = (s & 32'h0F0F_0F0F) + ((s >> 4) & 32'h0F0F_0F0F);
    s = (s & 32'h00FF_00FF) + ((s >> 8) & 32'h00FF_00FF);
    s = (s & 32'h0000_FFFF) + ((s >> 16) & 32'h0000_FFFF);
    return s[DIST_W-1:0];
  endfunction

endpackage

// ===== src/sfs_channels.sv =====
// Handshake channel interfaces for byte input and fingerprint results.
interface sfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       token_end;
  logic       message_end;

  modport source (output valid, output char_byte, output token_end, output message_end,
                  input ready);
  modport sink (input valid, input char_byte, input token_end, input message_end,
                output ready);
endinterface

interface sfs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fingerprint;
  logic [5:0]  distance;

  modport source (output valid, output fingerprint, output distance, input ready);
  modport sink (input valid, input fingerprint, input distance, output ready);
endinterface

// ===== src/sfs_token_hash.sv =====
// Running token hash, token length and token close detection.
module sfs_token_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_fire,
  input  logic [sfs_pkg::BYTE_W-1:0] char_byte,
  input  logic                      token_end,
  input  logic                      message_end,
  input  logic                      token_mode,
  input  logic [sfs_pkg::SIZE_W-1:0] token_size,
  output sfs_pkg::close_evt_t       evt_r
);
  import sfs_pkg::*;

  logic [HASH_W-1:0] hash_r, hash_nxt, hash_upd;
  logic [LEN_W-1:0]  len_r, len_nxt, len_upd;
  logic [SIZE_W-1:0] size_eff;
  logic              closing;
  logic              close;
  close_evt_t        evt_nxt;

  always_comb begin
    hash_upd = hash_r * HASH_MULT + {{(HASH_W-BYTE_W){1'b0}}, char_byte};
    len_upd  = (len_r == {LEN_W{1'b1}}) ? len_r : len_r + {{(LEN_W-1){1'b0}}, 1'b1};
    size_eff = (token_size == '0) ? {{(SIZE_W-1){1'b0}}, 1'b1} : token_size;
    closing  = token_mode ? token_end : (len_upd >= {{(LEN_W-SIZE_W){1'b0}}, size_eff});
    close    = closing | message_end;
    hash_nxt = close ? '0 : hash_upd;
    len_nxt  = close ? '0 : len_upd;
    evt_nxt.valid  = in_fire & close;
    evt_nxt.last   = message_end;
    evt_nxt.key    = hash_upd[KEY_W-1:0];
    evt_nxt.weight = token_mode ? len_upd : {{(LEN_W-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
      len_r  <= '0;
      evt_r  <= '0;
    end else begin
      if (in_fire) begin
        hash_r <= hash_nxt;
        len_r  <= len_nxt;
      end
      if (adv) begin
        evt_r <= evt_nxt;
      end
    end
  end

endmodule

// ===== src/sfs_tally_bank.sv =====
// Saturating per-bit tallies and fingerprint capture at message end.
module sfs_tally_bank #(
  parameter int HASH_BITS   = 32,
  parameter int TALLY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  sfs_pkg::close_evt_t         evt,
  output logic                        fp_valid_r,
  output logic [sfs_pkg::PRINT_W-1:0] fp_r
);
  import sfs_pkg::*;

  localparam int SUM_W = ((TALLY_WIDTH > LEN_W) ? TALLY_WIDTH : LEN_W) + 2;
  localparam logic signed [SUM_W-1:0] T_MAX =
    {{(SUM_W-TALLY_WIDTH+1){1'b0}}, {(TALLY_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] T_MIN = ~T_MAX;

  logic [PRINT_W-1:0] key_ext;
  logic [PRINT_W-1:0] fp_nxt;
  logic               upd;

  assign key_ext = {{(PRINT_W-KEY_W){1'b0}}, evt.key};
  assign upd     = adv & evt.valid;

  genvar g;
  generate
    for (g = 0; g < PRINT_W; g++) begin : g_lane
      if (g < HASH_BITS) begin : g_live
        logic signed [TALLY_WIDTH-1:0] tally_r, tally_nxt;
        logic signed [SUM_W-1:0]       t_ext, w_ext, sum;

        always_comb begin
          t_ext = {{(SUM_W-TALLY_WIDTH){tally_r[TALLY_WIDTH-1]}}, tally_r};
          w_ext = {{(SUM_W-LEN_W){1'b0}}, evt.weight};
          sum   = key_ext[g] ? (t_ext + w_ext) : (t_ext - w_ext);
          if (sum > T_MAX) begin
            tally_nxt = T_MAX[TALLY_WIDTH-1:0];
          end else if (sum < T_MIN) begin
            tally_nxt = T_MIN[TALLY_WIDTH-1:0];
          end else begin
            tally_nxt = sum[TALLY_WIDTH-1:0];
          end
        end

        assign fp_nxt[g] = ~tally_nxt[TALLY_WIDTH-1] & (|tally_nxt);

        always_ff @(posedge clk) begin
          if (!rst_n) begin
            tally_r <= '0;
          end else if (upd) begin
            tally_r <= evt.last ? '0 : tally_nxt;
          end
        end
      end else begin : g_dead
        assign fp_nxt[g] = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_valid_r <= 1'b0;
    end else if (adv) begin
      fp_valid_r <= evt.valid & evt.last;
    end
  end

  always_ff @(posedge clk) begin
    if (upd && evt.last) begin
      fp_r <= fp_nxt;
    end
  end

endmodule

// ===== src/sfs_out_stage.sv =====
// Hamming distance, result register and skid stage of the result channel.
module sfs_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fp_valid,
  input  logic [sfs_pkg::PRINT_W-1:0] fp,
  input  logic [sfs_pkg::PRINT_W-1:0] reference_print,
  input  logic                        out_ready,
  output logic                        adv,
  output logic                        out_valid_r,
  output sfs_pkg::result_t            out_r
);
  import sfs_pkg::*;

  logic    skid_valid_r;
  result_t skid_r;
  result_t res_nxt;
  logic    push;

  assign adv  = ~skid_valid_r;
  assign push = adv & fp_valid;

  always_comb begin
    res_nxt.fingerprint = fp;
    res_nxt.distance    = popcount32(fp ^ reference_print);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

endmodule

// ===== src/simhash_fingerprint_stream_core.sv =====
// Top level of the SimHash fingerprint stream core.
// Takes one message byte per cycle while the result channel keeps up, and emits one
// fingerprint and Hamming distance per message, on the transfer that carries message_end.
// A byte passes three register stages: the token hash stage (hash, length, close
// detection), the tally stage (all per-bit tallies update in parallel) and the result
// stage (distance, output register and skid register), so a byte can be taken in every
// cycle while the result channel keeps up. Input ready drops only while the skid
// register holds a result. Write configuration only while the core is idle.
module simhash_fingerprint_stream_core #(
  parameter int HASH_BITS   = 32,
  parameter int TALLY_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sfs_in_if.sink                         in_ch,
  sfs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  sfs_pkg::cfg_idx_t              cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sfs_pkg::*;

  logic               token_mode_r;
  logic [SIZE_W-1:0]  token_size_r;
  logic [PRINT_W-1:0] reference_print_r;

  logic               adv;
  logic               in_fire;
  close_evt_t         evt_r;
  logic               fp_valid_r;
  logic [PRINT_W-1:0] fp_r;
  logic               out_valid_r;
  result_t            out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_mode_r      <= 1'b0;
      token_size_r      <= 8'd4;
      reference_print_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOKEN_MODE:      token_mode_r      <= cfg_wdata[0];
        CFG_TOKEN_SIZE:      token_size_r      <= cfg_wdata[SIZE_W-1:0];
        CFG_REFERENCE_PRINT: reference_print_r <= cfg_wdata[PRINT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid & adv;

  sfs_token_hash u_hash (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_fire     (in_fire),
    .char_byte   (in_ch.char_byte),
    .token_end   (in_ch.token_end),
    .message_end (in_ch.message_end),
    .token_mode  (token_mode_r),
    .token_size  (token_size_r),
    .evt_r       (evt_r)
  );

  sfs_tally_bank #(
    .HASH_BITS   (HASH_BITS),
    .TALLY_WIDTH (TALLY_WIDTH)
  ) u_tally (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .evt        (evt_r),
    .fp_valid_r (fp_valid_r),
    .fp_r       (fp_r)
  );

  sfs_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .fp_valid        (fp_valid_r),
    .fp              (fp_r),
    .reference_print (reference_print_r),
    .out_ready       (out_ch.ready),
    .adv             (adv),
    .out_valid_r     (out_valid_r),
    .out_r           (out_r)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.fingerprint = out_r.fingerprint;
  assign out_ch.distance    = out_r.distance;

endmodule
